FILE: hdl/scpa_pkg.sv
// Shared types and constants for the size-class pool allocator.
// No dependencies; used by scpa_ctrl, scpa_dp and size_class_pool_allocator_unit.
package scpa_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int IDX_W       = 6;   // buffer index within a pool, up to 64 buffers
  localparam int POOL_MAX    = 64;

  localparam logic [31:0] REGION_BASE_RESET = 32'h6800_0000;
  localparam logic [31:0] POOL_SKIP         = 32'h0000_8000;  // pools start 32 KB up
  localparam logic [0:0]  USED_BIT          = 1'b1;

  // log2 of the buffer size, per class: 8K, 4K, 2K, 1K
  localparam int CLASS_SHIFT [NUM_CLASSES] = '{13, 12, 11, 10};

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CLS_8K = 2'd0,
    CLS_4K = 2'd1,
    CLS_2K = 2'd2,
    CLS_1K = 2'd3
  } size_class_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_ALLOC  = 2'd1,
    STAT_NOT_FOUND  = 2'd2,
    STAT_NONE_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    mode_t       mode;
    size_class_t size_class;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] buffer_address;
    status_t     status;
  } out_item_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // perform the request and load the result register
  } ctl_cmd_t;

endpackage

FILE: hdl/scpa_ctrl.sv
// Controller for the size-class pool allocator: request sequencing and handshakes.
// Depends on scpa_pkg.
module scpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output scpa_pkg::ctl_cmd_t cmd
);

  scpa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scpa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    in_stall    = 1'b1;
    // result register drains when taken
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      scpa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = scpa_pkg::S_EXEC;
        end
      end
      scpa_pkg::S_EXEC: begin
        // wait until the result register is empty or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = scpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = scpa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/scpa_dp.sv
// Datapath for the size-class pool allocator: used bitmaps, first-free search,
// address decode and result register. Depends on scpa_pkg.
module scpa_dp #(
  parameter int COUNT_8K = 8,
  parameter int COUNT_4K = 16,
  parameter int COUNT_2K = 32,
  parameter int COUNT_1K = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scpa_pkg::ctl_cmd_t  cmd,
  input  scpa_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  output scpa_pkg::out_item_t out_data
);

  localparam int NC = scpa_pkg::NUM_CLASSES;
  localparam int PM = scpa_pkg::POOL_MAX;
  localparam int CNT [NC] = '{COUNT_8K, COUNT_4K, COUNT_2K, COUNT_1K};

  // pool span in bytes and offset from the first pool
  localparam logic [31:0] SPAN [NC] = '{
    32'(COUNT_8K) << scpa_pkg::CLASS_SHIFT[0],
    32'(COUNT_4K) << scpa_pkg::CLASS_SHIFT[1],
    32'(COUNT_2K) << scpa_pkg::CLASS_SHIFT[2],
    32'(COUNT_1K) << scpa_pkg::CLASS_SHIFT[3]
  };
  localparam logic [31:0] OFF [NC] = '{
    32'd0,
    SPAN[0],
    SPAN[0] + SPAN[1],
    SPAN[0] + SPAN[1] + SPAN[2]
  };

  logic [31:0]        base_r;
  logic [31:0]        pool_start_r [NC];
  scpa_pkg::in_item_t req_r;
  scpa_pkg::out_item_t out_r, out_nxt;

  logic [COUNT_8K-1:0] used_8k_r, used_8k_nxt;
  logic [COUNT_4K-1:0] used_4k_r, used_4k_nxt;
  logic [COUNT_2K-1:0] used_2k_r, used_2k_nxt;
  logic [COUNT_1K-1:0] used_1k_r, used_1k_nxt;

  // combinational
  logic [PM-1:0]             usedx [NC];
  logic [PM-1:0]             avail;
  logic [PM-1:0]             first;
  logic [scpa_pkg::IDX_W-1:0] alloc_idx;
  logic [31:0]               delta [NC];
  logic                      hit [NC];
  logic                      hit_any;
  logic [1:0]                hit_cls;
  logic                      hit_aligned;
  logic [scpa_pkg::IDX_W-1:0] free_idx;
  logic [PM-1:0]             set_mask, clr_mask;
  logic [1:0]                upd_cls;
  logic                      sel_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= scpa_pkg::REGION_BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_data;
    end
  end

  // per-pool start addresses, refreshed every cycle from the base register
  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      pool_start_r[c] <= base_r + scpa_pkg::POOL_SKIP + OFF[c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_8k_r <= '0;
      used_4k_r <= '0;
      used_2k_r <= '0;
      used_1k_r <= '0;
    end else begin
      used_8k_r <= used_8k_nxt;
      used_4k_r <= used_4k_nxt;
      used_2k_r <= used_2k_nxt;
      used_1k_r <= used_1k_nxt;
    end
  end

  always_comb begin
    usedx[0] = PM'(used_8k_r);
    usedx[1] = PM'(used_4k_r);
    usedx[2] = PM'(used_2k_r);
    usedx[3] = PM'(used_1k_r);

    // allocate: isolate lowest free bit of the selected pool
    for (int i = 0; i < PM; i++) begin
      avail[i] = (i < CNT[req_r.size_class]) && !usedx[req_r.size_class][i];
    end
    first     = avail & (~avail + PM'(1));
    alloc_idx = '0;
    for (int i = 0; i < PM; i++) begin
      if (first[i]) begin
        alloc_idx = alloc_idx | scpa_pkg::IDX_W'(i);
      end
    end

    // free: locate the pool holding the address (pools do not overlap)
    hit_any     = 1'b0;
    hit_cls     = '0;
    hit_aligned = 1'b0;
    free_idx    = '0;
    for (int c = 0; c < NC; c++) begin
      delta[c] = req_r.free_address - pool_start_r[c];
      hit[c]   = delta[c] < SPAN[c];
    end
    for (int c = NC - 1; c >= 0; c--) begin
      if (hit[c]) begin
        hit_any     = 1'b1;
        hit_cls     = 2'(c);
        hit_aligned = (delta[c] & ((32'd1 << scpa_pkg::CLASS_SHIFT[c]) - 32'd1)) == 32'd0;
        free_idx    = scpa_pkg::IDX_W'(delta[c] >> scpa_pkg::CLASS_SHIFT[c]);
      end
    end
    sel_used = usedx[hit_cls][free_idx];

    set_mask = '0;
    clr_mask = '0;
    upd_cls  = req_r.size_class;
    out_nxt.buffer_address = '0;
    out_nxt.status         = scpa_pkg::STAT_NOT_FOUND;

    case (req_r.mode)
      scpa_pkg::MODE_ALLOC: begin
        out_nxt.status = scpa_pkg::STAT_NONE_FREE;
        if (|avail) begin
          set_mask = first;
          out_nxt.buffer_address = pool_start_r[req_r.size_class]
              + (32'(alloc_idx) << scpa_pkg::CLASS_SHIFT[req_r.size_class]);
          out_nxt.status = scpa_pkg::STAT_OK;
        end
      end
      scpa_pkg::MODE_FREE: begin
        upd_cls = hit_cls;
        if (hit_any && hit_aligned) begin
          if (sel_used == scpa_pkg::USED_BIT) begin
            clr_mask       = PM'(1) << free_idx;
            out_nxt.status = scpa_pkg::STAT_OK;
          end else begin
            out_nxt.status = scpa_pkg::STAT_NOT_ALLOC;
          end
        end
      end
      default: begin
        out_nxt.status = scpa_pkg::STAT_NOT_FOUND;
      end
    endcase

    used_8k_nxt = used_8k_r;
    used_4k_nxt = used_4k_r;
    used_2k_nxt = used_2k_r;
    used_1k_nxt = used_1k_r;
    if (cmd.exec) begin
      case (upd_cls)
        scpa_pkg::CLS_8K: used_8k_nxt = COUNT_8K'((usedx[0] | set_mask) & ~clr_mask);
        scpa_pkg::CLS_4K: used_4k_nxt = COUNT_4K'((usedx[1] | set_mask) & ~clr_mask);
        scpa_pkg::CLS_2K: used_2k_nxt = COUNT_2K'((usedx[2] | set_mask) & ~clr_mask);
        scpa_pkg::CLS_1K: used_1k_nxt = COUNT_1K'((usedx[3] | set_mask) & ~clr_mask);
        default: begin
          used_1k_nxt = used_1k_r;
        end
      endcase
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/size_class_pool_allocator_unit.sv
// Top level of the size-class pool allocator: four fixed-size buffer pools.
// Depends on scpa_pkg, scpa_ctrl and scpa_dp.
//
//  channel | handshake            | payload                    | direction
//  --------+----------------------+----------------------------+----------
//  in_     | in_valid / in_stall  | in_data  (in_item_t)       | request
//  out_    | out_valid / out_stall| out_data (out_item_t)      | result
//  cfg_    | cfg_valid / cfg_ready| cfg_data (region base)     | config
//
// Each item first has its request latched, then the used bitmap is searched
// (or the free address decoded) and the result register loaded.
// A new item is taken while the previous result still waits downstream; the
// execute step holds only while the result register is full and stalled.
// Reset (rst_n low, synchronous) marks every buffer free and restores the
// region base; cfg_ready is always high.
module size_class_pool_allocator_unit #(
  parameter int COUNT_8K = 8,
  parameter int COUNT_4K = 16,
  parameter int COUNT_2K = 32,
  parameter int COUNT_1K = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scpa_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  scpa_pkg::ctl_cmd_t cmd;

  // config writes land directly in the base register
  assign cfg_ready = 1'b1;

  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  scpa_dp #(
    .COUNT_8K (COUNT_8K),
    .COUNT_4K (COUNT_4K),
    .COUNT_2K (COUNT_2K),
    .COUNT_1K (COUNT_1K)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

FILE: test/size_class_pool_allocator_unit_tb.sv
// Self-checking testbench for size_class_pool_allocator_unit.
// It predicts every allocate/free result in-line and checks the results in order.
// Depends on scpa_pkg and the allocator RTL.
module size_class_pool_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_8K    = 8;
  localparam int COUNT_4K    = 16;
  localparam int COUNT_2K    = 32;
  localparam int COUNT_1K    = 64;
  localparam int POOL_CNT [scpa_pkg::NUM_CLASSES] = '{COUNT_8K, COUNT_4K, COUNT_2K, COUNT_1K};

  // The slowest legal run has the longest idle gaps and output stalls on each of
  // ~450 items; the limit leaves a wide margin on top.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_PRINTS  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  scpa_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  scpa_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [31:0]         cfg_data = '0;

  size_class_pool_allocator_unit #(
    .COUNT_8K(COUNT_8K),
    .COUNT_4K(COUNT_4K),
    .COUNT_2K(COUNT_2K),
    .COUNT_1K(COUNT_1K)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the allocator: region base and one used bitmap per pool.
  logic [31:0] base_q;
  logic [63:0] used_map [scpa_pkg::NUM_CLASSES];

  scpa_pkg::in_item_t  pending_q [$];   // requests waiting to be driven
  scpa_pkg::out_item_t expected_q [$];  // predicted results, oldest first

  int n_queued  = 0;
  int n_sent    = 0;
  int n_results = 0;
  int n_errors  = 0;
  int n_bases   = 0;
  int n_cycles  = 0;
  int n_status [4] = '{0, 0, 0, 0};
  int in_wait   = 0;
  int stall_left = 0;
  bit calm_in   = 1'b0;
  bit calm_out  = 1'b0;

  // Byte offset of a pool's first buffer from the pool area start.
  // pool_off(NUM_CLASSES) is the span of all four pools.
  function automatic int pool_off(input int c);
    int off;
    off = 0;
    for (int j = 0; j < c; j++) off += POOL_CNT[j] << scpa_pkg::CLASS_SHIFT[j];
    return off;
  endfunction

  function automatic logic [31:0] buf_start(input logic [31:0] base, input int c,
                                            input int k);
    return base + scpa_pkg::POOL_SKIP + 32'(pool_off(c)) +
           (32'(k) << scpa_pkg::CLASS_SHIFT[c]);
  endfunction

  // Gap or stall length per item; calm stretches run with no idling at all.
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Allocator behavior: works out the result of one request and updates the
  // shadow bitmaps.  Addresses wrap modulo 2^32.
  function automatic scpa_pkg::out_item_t predict_result(input scpa_pkg::in_item_t it);
    scpa_pkg::out_item_t r;
    logic [31:0] start, rel, pool_lo, span, d;
    logic [63:0] avail, mask;
    int          c, k;
    bit          hit;
    r.buffer_address = '0;
    r.status = scpa_pkg::STAT_NOT_FOUND;
    start = base_q + scpa_pkg::POOL_SKIP;
    hit = 1'b0;
    if (it.mode == scpa_pkg::MODE_ALLOC) begin
      c = int'(it.size_class);
      mask = (POOL_CNT[c] >= 64) ? '1 : ((64'd1 << POOL_CNT[c]) - 64'd1);
      avail = ~used_map[c] & mask;
      r.status = scpa_pkg::STAT_NONE_FREE;
      // lowest-numbered free buffer wins
      for (k = 0; k < 64; k++) begin
        if (!hit && avail[k]) begin
          hit = 1'b1;
          used_map[c][k] = 1'b1;
          r.buffer_address = start + 32'(pool_off(c)) +
                             (32'(k) << scpa_pkg::CLASS_SHIFT[c]);
          r.status = scpa_pkg::STAT_OK;
        end
      end
    end else begin
      rel = it.free_address - start;
      for (c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin
        if (!hit) begin
          pool_lo = 32'(pool_off(c));
          span = 32'(POOL_CNT[c]) << scpa_pkg::CLASS_SHIFT[c];
          d = rel - pool_lo;
          if (rel >= pool_lo && d < span) begin
            hit = 1'b1;
            // inside a pool but not on a buffer start stays "not found"
            if ((d & ((32'd1 << scpa_pkg::CLASS_SHIFT[c]) - 32'd1)) == 32'd0) begin
              k = int'(d >> scpa_pkg::CLASS_SHIFT[c]);
              if (used_map[c][k]) begin
                used_map[c][k] = 1'b0;
                r.status = scpa_pkg::STAT_OK;
              end else begin
                r.status = scpa_pkg::STAT_NOT_ALLOC;
              end
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < MAX_PRINTS)
      $display("ERROR result %0d: %s got %h want %h", n_results, what, got, want);
    n_errors++;
  endtask

  function automatic scpa_pkg::in_item_t mk_item(input scpa_pkg::mode_t m,
                                                 input scpa_pkg::size_class_t c,
                                                 input logic [31:0] a);
    scpa_pkg::in_item_t it;
    it.mode = m;
    it.size_class = c;
    it.free_address = a;
    return it;
  endfunction

  task automatic queue_item(input scpa_pkg::in_item_t it);
    pending_q.push_back(it);
    n_queued++;
  endtask

  // Mostly alloc/free traffic on real buffer starts, with low buffer indices
  // favored so frees often hit allocated buffers; the rest is address noise.
  task automatic queue_random(input int n, input logic [31:0] base);
    scpa_pkg::in_item_t it;
    int pick, c, k, lim;
    repeat (n) begin
      it.free_address = $urandom();
      it.size_class = scpa_pkg::size_class_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        it.mode = scpa_pkg::MODE_ALLOC;
      end else begin
        it.mode = scpa_pkg::MODE_FREE;
        c = int'(it.size_class);
        lim = (POOL_CNT[c] < 12) ? POOL_CNT[c] : 12;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POOL_CNT[c] - 1)
                                        : $urandom_range(0, lim - 1);
        if (pick < 88)
          it.free_address = buf_start(base, c, k);
        else if (pick < 93)  // inside a buffer
          it.free_address = buf_start(base, c, k) +
                            32'($urandom_range(1, (1 << scpa_pkg::CLASS_SHIFT[c]) - 1));
        else if (pick < 96)  // in the skip area below the pools
          it.free_address = base + 32'($urandom_range(0, int'(scpa_pkg::POOL_SKIP) - 1));
        else if (pick < 98)  // just past the last pool
          it.free_address = base + scpa_pkg::POOL_SKIP +
                            32'(pool_off(scpa_pkg::NUM_CLASSES)) +
                            32'($urandom_range(0, 4095));
        // otherwise keep the fully random address
      end
      queue_item(it);
    end
  endtask

  // Waits until every queued request has produced its result, then lets the
  // pipeline drain before anything touches the register.
  task automatic wait_idle;
    while (n_results < n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_q = v;
    cfg_valid <= 1'b0;
    n_bases++;
  endtask

  // Request side: one item in flight on the port, gap drawn per item.
  always @(posedge clk) begin : request_driver
    bit accept;
    accept = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait  <= 0;
    end else begin
      if (accept) begin
        expected_q.push_back(predict_result(in_data));
        n_sent++;
        if (n_sent % 40 == 0) calm_in = ($urandom_range(0, 3) == 0);
      end
      if (accept || !in_valid) begin
        if (in_wait > 0) begin
          in_wait  <= in_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
          in_wait  <= draw_gap(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each accepted item against the oldest prediction,
  // then stall for a drawn number of cycles.
  always @(posedge clk) begin : result_monitor
    scpa_pkg::out_item_t want;
    int g;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request", out_data.buffer_address, '0);
        end else begin
          want = expected_q.pop_front();
          n_status[int'(want.status)]++;
          if (out_data.buffer_address !== want.buffer_address)
            report_mismatch("buffer_address", out_data.buffer_address,
                            want.buffer_address);
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
        if (n_results % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
        g = draw_gap(calm_out);
        stall_left <= g;
        out_stall  <= (g != 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= (stall_left > 1);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               n_cycles, n_results, n_queued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] b;
    base_q = scpa_pkg::REGION_BASE_RESET;
    for (int c = 0; c < scpa_pkg::NUM_CLASSES; c++) used_map[c] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset base, never written: directed corner cases first.
    b = scpa_pkg::REGION_BASE_RESET;
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, '0));
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_4K, '0));
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_2K, '0));
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_1K, '0));
    // fill the 8K pool; the free address must be ignored on allocate
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, 32'hFFFF_FFFF));
    repeat (6) queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, '0));
    // pool exhausted
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, '0));
    // ok
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, buf_start(b, 0, 0)));
    // already free
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_1K, buf_start(b, 0, 0)));
    // mid-buffer
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K,
                       buf_start(b, 0, 1) + 32'd1));
    // below pools
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, b));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K,
                       b + scpa_pkg::POOL_SKIP + 32'(pool_off(scpa_pkg::NUM_CLASSES))));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_2K, 32'hFFFF_FFFF));
    // never used
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K,
                       buf_start(b, 3, COUNT_1K - 1)));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, buf_start(b, 1, 0)));
    // reuses buffer 0
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, '0));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, buf_start(b, 2, 0)));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, buf_start(b, 3, 0)));
    queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K,
                       buf_start(b, 0, COUNT_8K - 1)));
    queue_random(80, b);
    wait_idle();

    // Lowest base.
    b = 32'h0000_0000;
    write_base(b);
    queue_random(80, b);
    wait_idle();

    // Pools start exactly at address 0: empty the 8K pool, then the next
    // 8K allocation must return address 0 with an ok status.
    b = 32'hFFFF_8000;
    write_base(b);
    for (int k = 0; k < COUNT_8K; k++)
      queue_item(mk_item(scpa_pkg::MODE_FREE, scpa_pkg::CLS_8K, buf_start(b, 0, k)));
    queue_item(mk_item(scpa_pkg::MODE_ALLOC, scpa_pkg::CLS_8K, '0));
    queue_random(80, b);
    wait_idle();

    // Highest base: everything wraps.
    b = 32'hFFFF_FFFF;
    write_base(b);
    queue_random(80, b);
    wait_idle();

    // 8K pool straddles the 2^32 boundary.
    b = 32'hFFFF_0000;
    write_base(b);
    queue_random(50, b);
    wait_idle();

    b = $urandom();
    write_base(b);
    queue_random(50, b);
    wait_idle();

    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results never seen", 32'(expected_q.size()), '0);

    $display("Covered %0d requests under %0d written region bases plus the reset base",
             n_sent, n_bases);
    $display("Result mix: %0d ok, %0d not allocated, %0d not found, %0d none free",
             n_status[scpa_pkg::STAT_OK], n_status[scpa_pkg::STAT_NOT_ALLOC],
             n_status[scpa_pkg::STAT_NOT_FOUND], n_status[scpa_pkg::STAT_NONE_FREE]);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/scpa_pkg.sv
hdl/scpa_ctrl.sv
hdl/scpa_dp.sv
hdl/size_class_pool_allocator_unit.sv
test/size_class_pool_allocator_unit_tb.sv
